// ----- rtl/sarb_pkg.sv -----
// Shared constants for the sample accumulate/resolve buffer.
// No dependencies; used by the top level, the checker and the testbench.
`default_nettype none
package sarb_pkg;
   localparam int MaxWidth      = 256;
   localparam int MaxHeight     = 256;
   localparam int MaxComponents = 4;
   localparam int CountBits     = 16;
   localparam int PixDepth      = MaxWidth * MaxHeight;
   localparam int IdxBits       = $clog2(PixDepth);
   localparam int SumBits       = 32;
   localparam int WordBits      = MaxComponents * SumBits + CountBits;
   localparam int DvdBits       = 40;
   localparam int StepBits      = $clog2(DvdBits);

   localparam int ReqDataBits   = 152;
   localparam int RspDataBits   = 144;
   localparam int CsrAddrBits   = 5;

   // item kinds
   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_RESOLVE = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   // component formats
   localparam logic [2:0] FMT_INT32  = 3'd0;
   localparam logic [2:0] FMT_UNORM8 = 3'd1;
   localparam logic [2:0] FMT_SNORM8 = 3'd2;

   // register indexes
   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_COUNT  = 3'd2;
   localparam logic [2:0] REG_FORMAT = 3'd3;
   localparam logic [2:0] REG_MS     = 3'd4;
endpackage
`default_nettype wire

// ----- rtl/sample_accumulate_resolve_buffer_top.sv -----
// Per-pixel sample accumulation and resolve buffer. Depends on sarb_pkg, sarb_ram.
//
// One pixel memory (65536 words of four 32-bit sums plus a 16-bit count) holds
// the state. After reset the block runs a clearing pass over all 65536 words,
// one word per cycle, and takes no item until it ends; CSR writes work throughout.
// Items are handled one at a time. Every item first reads its pixel word from
// memory. A multisampled write then writes the saturated sums back.
// Out-of-frame items, kind 3 and resolves with nothing to resolve (zero count
// or multisampling off) also return to idle after the read, with no result.
// Direct writes, clears and resolves go through a scaling state, four parallel
// restoring dividers (one quotient bit per cycle, 40-bit dividend) and a finish state.
// The result register lets the next item be taken while a result waits.
// CSR map: 0x00 frame_width, 0x04 frame_height, 0x08 component_count,
// 0x0C component_format, 0x10 multisampled.
`default_nettype none
module sample_accumulate_resolve_buffer_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req_tdata: pixel_x, pixel_y, value_count, value_0..value_3, zero pad
   input  wire logic [sarb_pkg::ReqDataBits-1:0] req_tdata,
   input  wire logic [1:0]                     req_tuser,   // kind
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: pixel_index, out_0..out_3
   output logic [sarb_pkg::RspDataBits-1:0]    rsp_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [sarb_pkg::CsrAddrBits-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import sarb_pkg::*;

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   // config registers
   logic [8:0] width_ff, height_ff;
   logic [2:0] ccount_ff, format_ff;
   logic       ms_ff;

   logic [2:0]        state_ff, state_in;
   logic [IdxBits-1:0] clr_ff, clr_in;
   logic [IdxBits-1:0] idx_ff, idx_in;
   logic [1:0]        kind_ff, kind_in;
   logic              ok_ff, ok_in;
   logic [2:0]        vc_ff, vc_in;
   logic signed [SumBits-1:0] val_ff [MaxComponents];
   logic signed [SumBits-1:0] val_in [MaxComponents];
   logic signed [SumBits-1:0] op_ff [MaxComponents];
   logic signed [SumBits-1:0] op_in [MaxComponents];
   logic [MaxComponents-1:0]  neg_ff, neg_in;
   logic [DvdBits-1:0]        dvd_ff [MaxComponents];
   logic [DvdBits-1:0]        dvd_in [MaxComponents];
   logic [CountBits-1:0]      rem_ff [MaxComponents];
   logic [CountBits-1:0]      rem_in [MaxComponents];
   logic [CountBits-1:0]      n_ff, n_in;
   logic [StepBits-1:0]       step_ff, step_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RspDataBits-1:0]    rsp_data_ff, rsp_data_in;

   // RAM
   logic               wr_en;
   logic [IdxBits-1:0] wr_addr, rd_addr;
   logic [WordBits-1:0] wr_data, rd_data;

   sarb_ram #(.WIDTH(WordBits), .DEPTH(PixDepth)) u_pix_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // request fields
   logic [7:0] req_x, req_y;
   assign req_x = req_tdata[7:0];
   assign req_y = req_tdata[15:8];

   logic [8:0] w_eff, h_eff;
   logic [2:0] cc_eff;
   assign w_eff  = (width_ff > 9'(MaxWidth)) ? 9'(MaxWidth) : width_ff;
   assign h_eff  = (height_ff > 9'(MaxHeight)) ? 9'(MaxHeight) : height_ff;
   assign cc_eff = (ccount_ff > 3'(MaxComponents)) ? 3'(MaxComponents) : ccount_ff;

   logic [16:0] row_base;
   logic [IdxBits-1:0] req_idx;
   assign row_base = 17'(req_y) * 17'(w_eff);
   assign req_idx  = IdxBits'(row_base + 17'(req_x));

   logic req_fire, csr_wr;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_WIDTH:  csr_prdata = 32'(width_ff);
         REG_HEIGHT: csr_prdata = 32'(height_ff);
         REG_COUNT:  csr_prdata = 32'(ccount_ff);
         REG_FORMAT: csr_prdata = 32'(format_ff);
         REG_MS:     csr_prdata = 32'(ms_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // scaling factor by format
   logic [7:0] scale;
   always_comb begin
      case (format_ff)
         FMT_UNORM8: scale = 8'd255;
         FMT_SNORM8: scale = 8'd127;
         default:    scale = 8'd1;
      endcase
   end

   logic signed [SumBits:0] sum_ext [MaxComponents];
   logic [SumBits-1:0]  sat_sum [MaxComponents];
   logic [SumBits-1:0]  mag [MaxComponents];
   logic [CountBits:0]  rem_sh [MaxComponents];
   logic [23:0]         q16 [MaxComponents];
   logic [SumBits-1:0]  res [MaxComponents];
   logic [CountBits-1:0] rd_count;
   logic [SumBits-1:0]  rd_sum [MaxComponents];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      ok_in        = ok_ff;
      vc_in        = vc_ff;
      neg_in       = neg_ff;
      n_in         = n_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '0;
      rd_addr      = req_idx;
      rd_count     = rd_data[WordBits-1 -: CountBits];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      for (int c = 0; c < MaxComponents; c++) begin
         val_in[c] = val_ff[c];
         op_in[c]  = op_ff[c];
         dvd_in[c] = dvd_ff[c];
         rem_in[c] = rem_ff[c];
         rd_sum[c] = rd_data[c*SumBits +: SumBits];
         // both operands sign-extended to 33 bits
         sum_ext[c] = (SumBits+1)'($signed(rd_sum[c]))
                    + (SumBits+1)'($signed((c < int'(vc_ff)) ? val_ff[c] : '0));
         if (sum_ext[c][SumBits] != sum_ext[c][SumBits-1]) begin
            sat_sum[c] = sum_ext[c][SumBits] ? {1'b1, {(SumBits-1){1'b0}}}
                                             : {1'b0, {(SumBits-1){1'b1}}};
         end else begin
            sat_sum[c] = sum_ext[c][SumBits-1:0];
         end
         mag[c]    = op_ff[c][SumBits-1] ? (~op_ff[c] + 1'b1) : op_ff[c];
         rem_sh[c] = {rem_ff[c], dvd_ff[c][DvdBits-1]};
         q16[c]    = dvd_ff[c][DvdBits-1:16];
         case (format_ff)
            FMT_UNORM8: begin
               if (neg_ff[c]) res[c] = '0;
               else if (q16[c] > 24'd255) res[c] = 32'd255;
               else res[c] = 32'(q16[c]);
            end
            FMT_SNORM8: begin
               // negative byte kept as 8 bits, zero-extended
               if (neg_ff[c]) res[c] = (q16[c] > 24'd128) ? 32'h80
                                       : {24'd0, ~q16[c][7:0] + 8'd1};
               else if (q16[c] > 24'd127) res[c] = 32'h7F;
               else res[c] = 32'(q16[c]);
            end
            default: begin
               res[c] = neg_ff[c] ? (~dvd_ff[c][31:0] + 32'd1) : dvd_ff[c][31:0];
            end
         endcase
      end

      unique case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               idx_in  = req_idx;
               kind_in = req_tuser;
               vc_in   = req_tdata[18:16];
               ok_in   = ({1'b0, req_x} < w_eff) && ({1'b0, req_y} < h_eff)
                         && (req_tuser != KIND_UNUSED);
               for (int c = 0; c < MaxComponents; c++) begin
                  val_in[c] = req_tdata[19 + c*SumBits +: SumBits];
               end
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_IDLE;
            n_in     = CountBits'(1);
            for (int c = 0; c < MaxComponents; c++) begin
               op_in[c] = (c < int'(vc_ff)) ? val_ff[c] : '0;
            end
            if (ok_ff) begin
               case (kind_ff)
                  KIND_WRITE: begin
                     if (ms_ff) begin
                        wr_en = 1'b1;
                        wr_data = rd_data;
                        for (int c = 0; c < MaxComponents; c++) begin
                           if (c < int'(cc_eff)) wr_data[c*SumBits +: SumBits] = sat_sum[c];
                        end
                        if (~&rd_count) wr_data[WordBits-1 -: CountBits] = rd_count + 1'b1;
                     end else begin
                        state_in = S_MUL;
                     end
                  end
                  KIND_RESOLVE: begin
                     if (ms_ff && rd_count != '0) begin
                        n_in = rd_count;
                        for (int c = 0; c < MaxComponents; c++) op_in[c] = rd_sum[c];
                        state_in = S_MUL;
                     end
                  end
                  default: begin   // clear
                     if (ms_ff) wr_en = 1'b1;
                     state_in = S_MUL;
                  end
               endcase
            end
         end
         S_MUL: begin
            for (int c = 0; c < MaxComponents; c++) begin
               neg_in[c] = op_ff[c][SumBits-1];
               dvd_in[c] = DvdBits'(mag[c]) * DvdBits'(scale);
               rem_in[c] = '0;
            end
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            for (int c = 0; c < MaxComponents; c++) begin
               if (rem_sh[c] >= {1'b0, n_ff}) begin
                  rem_in[c] = CountBits'(rem_sh[c] - {1'b0, n_ff});
                  dvd_in[c] = {dvd_ff[c][DvdBits-2:0], 1'b1};
               end else begin
                  rem_in[c] = rem_sh[c][CountBits-1:0];
                  dvd_in[c] = {dvd_ff[c][DvdBits-2:0], 1'b0};
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == StepBits'(DvdBits-1)) state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in[IdxBits-1:0] = idx_ff;
               for (int c = 0; c < MaxComponents; c++) begin
                  rsp_data_in[IdxBits + c*SumBits +: SumBits] =
                     (c < int'(cc_eff)) ? res[c] : '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         ccount_ff    <= 3'd4;
         format_ff    <= FMT_INT32;
         ms_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            unique case (csr_paddr[4:2])
               REG_WIDTH:  width_ff  <= csr_pwdata[8:0];
               REG_HEIGHT: height_ff <= csr_pwdata[8:0];
               REG_COUNT:  ccount_ff <= csr_pwdata[2:0];
               REG_FORMAT: format_ff <= csr_pwdata[2:0];
               REG_MS:     ms_ff     <= csr_pwdata[0];
               default:    ;
            endcase
         end
      end
      idx_ff      <= idx_in;
      kind_ff     <= kind_in;
      ok_ff       <= ok_in;
      vc_ff       <= vc_in;
      neg_ff      <= neg_in;
      n_ff        <= n_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      for (int c = 0; c < MaxComponents; c++) begin
         val_ff[c] <= val_in[c];
         op_ff[c]  <= op_in[c];
         dvd_ff[c] <= dvd_in[c];
         rem_ff[c] <= rem_in[c];
      end
   end
endmodule
`default_nettype wire

// ----- rtl/sarb_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module sarb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/sarb_checker.sv -----
// Port-level checks for the accumulate/resolve buffer, bound to the top level.
// Depends on sarb_pkg.
`default_nettype none
module sarb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [sarb_pkg::RspDataBits-1:0] rsp_tdata,
   input wire logic                           csr_pready
);
   // held result must not change until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset starts the clearing pass: no intake, no result
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("activity right after reset");

   // one item in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transfer taken back to back");

   a_csr_ready: assert property (@(posedge clock) csr_pready)
      else $error("csr port not ready");
endmodule

bind sample_accumulate_resolve_buffer_top sarb_checker u_sarb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .csr_pready(csr_pready)
);
`default_nettype wire

// ----- bench/tb_sample_accumulate_resolve_buffer_top.sv -----
// Testbench for sample_accumulate_resolve_buffer_top: streams write, resolve and clear
// transfers, predicts every result and checks it. Depends on sarb_pkg and the top level.
`default_nettype none
module tb_sample_accumulate_resolve_buffer_top;
   import sarb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 60;    // longer than the divider path

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       x;
      logic [7:0]       y;
      logic [2:0]       vcount;
      logic [3:0][31:0] vals;
   } sample_item_t;

   typedef struct packed {
      logic [15:0]      index;
      logic [3:0][31:0] outs;
   } pixel_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [RspDataBits-1:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CsrAddrBits-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sample_accumulate_resolve_buffer_top DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the block's registers and pixel memory
   int unsigned width_q, height_q, comps_q, fmt_q, ms_q;
   int pix_sum [PixDepth][4];
   int unsigned pix_count [PixDepth];

   sample_item_t  item_queue[$];
   pixel_result_t pending_pixels[$];
   sample_item_t  cur_item;

   int  fail_count = 0;
   int  cycle_count = 0;
   bit  calm = 1'b0;        // no idling on either side while set
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------
   function automatic logic [31:0] scale_component(longint v, longint n);
      longint r;
      case (fmt_q[2:0])
         FMT_UNORM8: begin
            r = (v * 255) / (n * 65536);
            r = r < 0 ? 0 : (r > 255 ? 255 : r);
            return r[31:0];
         end
         FMT_SNORM8: begin
            r = (v * 127) / (n * 65536);
            r = r < -128 ? -128 : (r > 127 ? 127 : r);
            return {24'b0, r[7:0]};
         end
         default: begin
            // int32 and unknown codes; Q16.16 input applies only to the 8-bit formats
            r = v / n;
            return r[31:0];
         end
      endcase
   endfunction

   task automatic record_item(sample_item_t it);
      int unsigned w, h, cc, idx;
      longint v, s;
      pixel_result_t e;
      w = width_q > MaxWidth ? MaxWidth : width_q;
      h = height_q > MaxHeight ? MaxHeight : height_q;
      cc = comps_q > MaxComponents ? MaxComponents : comps_q;
      if (it.x >= w || it.y >= h || it.kind == KIND_UNUSED) return;
      idx = it.y * w + it.x;
      e.index = idx[15:0];
      e.outs = '0;
      if (it.kind == KIND_RESOLVE) begin
         if (ms_q == 0 || pix_count[idx] == 0) return;
         for (int c = 0; c < cc; c++)
            e.outs[c] = scale_component(pix_sum[idx][c], pix_count[idx]);
         pending_pixels.push_back(e);
         return;
      end
      if (it.kind == KIND_WRITE && ms_q != 0) begin
         for (int c = 0; c < cc; c++) begin
            v = (c < it.vcount) ? longint'(signed'(it.vals[c])) : 0;
            s = pix_sum[idx][c] + v;
            s = s < -64'sd2147483648 ? -64'sd2147483648 : (s > 64'sd2147483647 ? 64'sd2147483647 : s);
            pix_sum[idx][c] = s[31:0];
         end
         if (pix_count[idx] < (1 << CountBits) - 1) pix_count[idx]++;
         return;
      end
      // direct write or clear: converted input values go out at once
      if (it.kind == KIND_CLEAR && ms_q != 0) begin
         for (int c = 0; c < 4; c++) pix_sum[idx][c] = 0;
         pix_count[idx] = 0;
      end
      for (int c = 0; c < cc; c++) begin
         v = (c < it.vcount) ? longint'(signed'(it.vals[c])) : 0;
         e.outs[c] = scale_component(v, 1);
      end
      pending_pixels.push_back(e);
   endtask

   // ---------------------------------------------------------------
   // Driver: one transfer per handshake, prediction at acceptance
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) record_item(cur_item);
         if (item_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
            cur_item = item_queue.pop_front();
            req_tdata <= {5'b0, cur_item.vals, cur_item.vcount, cur_item.y, cur_item.x};
            req_tuser <= cur_item.kind;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compares each result transfer with the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      pixel_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[15:0] !== want.index) begin
               $display("%0t: pixel_index expected %0d actual %0d",
                        $time, want.index, rsp_tdata[15:0]);
               fail_count++;
            end
            for (int c = 0; c < 4; c++)
               if (rsp_tdata[16 + 32*c +: 32] !== want.outs[c]) begin
                  $display("%0t: out_%0d expected %h actual %h",
                           $time, c, want.outs[c], rsp_tdata[16 + 32*c +: 32]);
                  fail_count++;
               end
         end
      end
      // long hold-off lets the block fill up and stall its input
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(0, 99) >= 26;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Register access and stimulus
   // ---------------------------------------------------------------
   task automatic csr_write(logic [2:0] reg_idx, int unsigned value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (reg_idx)
         REG_WIDTH:  width_q = value & 32'h1FF;
         REG_HEIGHT: height_q = value & 32'h1FF;
         REG_COUNT:  comps_q = value & 32'h7;
         REG_FORMAT: fmt_q = value & 32'h7;
         default:    ms_q = value & 32'h1;
      endcase
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned cc,
                            int unsigned fmt, int unsigned ms);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      csr_write(REG_COUNT, cc);
      csr_write(REG_FORMAT, fmt);
      csr_write(REG_MS, ms);
   endtask

   // all transfers sent, all results back, then let a silent item drain
   task automatic drain();
      while (item_queue.size() != 0 || req_tvalid || pending_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic sample_item_t mk(logic [1:0] kind, logic [7:0] x, logic [7:0] y,
                                      logic [2:0] vc, logic [31:0] a, logic [31:0] b,
                                      logic [31:0] c, logic [31:0] d);
      sample_item_t it;
      it.kind = kind; it.x = x; it.y = y; it.vcount = vc;
      it.vals = {d, c, b, a};
      return it;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return int'($urandom_range(0, 524288)) - 262144;  // about +-4.0
      endcase
   endfunction

   function automatic sample_item_t rand_item();
      sample_item_t it;
      int unsigned w, h, k;
      w = width_q > MaxWidth ? MaxWidth : width_q;
      h = height_q > MaxHeight ? MaxHeight : height_q;
      k = $urandom_range(0, 99);
      if (ms_q != 0)
         it.kind = k < 55 ? KIND_WRITE : (k < 80 ? KIND_RESOLVE : (k < 95 ? KIND_CLEAR : KIND_UNUSED));
      else
         it.kind = k < 60 ? KIND_WRITE : (k < 85 ? KIND_CLEAR : (k < 95 ? KIND_RESOLVE : KIND_UNUSED));
      // mostly a small corner so pixels are hit again; some fully random
      k = $urandom_range(0, 99);
      if (k < 10) begin
         it.x = 8'($urandom_range(0, 255));
         it.y = 8'($urandom_range(0, 255));
      end else if (k < 20) begin
         it.x = 8'($urandom_range(0, w - 1));
         it.y = 8'($urandom_range(0, h - 1));
      end else begin
         it.x = 8'($urandom_range(0, (w < 6 ? w : 6) - 1));
         it.y = 8'($urandom_range(0, (h < 4 ? h : 4) - 1));
      end
      it.vcount = $urandom_range(0, 3) == 0 ? 3'($urandom_range(0, 7)) : 3'd4;
      for (int c = 0; c < 4; c++) it.vals[c] = rand_value();
      return it;
   endfunction

   initial begin
      int unsigned phase_cfg [10][6] = '{
         '{1, 1, 4, 0, 1, 40},        // single pixel frame
         '{4, 3, 4, 1, 1, 80},
         '{5, 2, 3, 2, 1, 80},
         '{3, 3, 2, 3, 1, 60},
         '{256, 256, 4, 4, 1, 60},
         '{2, 256, 0, 0, 1, 40},      // no components
         '{7, 5, 7, 7, 1, 60},        // count above max, unknown format
         '{256, 1, 1, 1, 0, 60},
         '{16, 16, 4, 2, 0, 60},
         '{8, 8, 4, 0, 1, 80}};
      width_q = 256; height_q = 256; comps_q = 4; fmt_q = 0; ms_q = 0;
      for (int i = 0; i < PixDepth; i++) begin
         pix_count[i] = 0;
         for (int c = 0; c < 4; c++) pix_sum[i][c] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes in the reset setting (direct int32)
      configure(256, 256, 4, 0, 0);
      item_queue.push_back(mk(KIND_WRITE, 255, 255, 4, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'hFFFF_FFFF, 0));
      item_queue.push_back(mk(KIND_WRITE, 0, 0, 0, 1, 2, 3, 4));
      item_queue.push_back(mk(KIND_WRITE, 170, 85, 7, 32'h5555_5555, 32'hAAAA_AAAA, 7, -7));
      item_queue.push_back(mk(KIND_WRITE, 85, 170, 2, 10, -10, 32'h7FFF_FFFF, 1));
      item_queue.push_back(mk(KIND_UNUSED, 1, 1, 4, 1, 1, 1, 1));
      item_queue.push_back(mk(KIND_RESOLVE, 1, 1, 4, 0, 0, 0, 0));
      item_queue.push_back(mk(KIND_CLEAR, 128, 1, 3, 32'h0001_0000, -1, 5, 9));
      drain();

      // directed: saturation, zero-count resolve, out of frame on a 1x1 frame
      configure(1, 1, 4, 0, 1);
      item_queue.push_back(mk(KIND_RESOLVE, 0, 0, 4, 0, 0, 0, 0));
      item_queue.push_back(mk(KIND_WRITE, 0, 0, 4, 32'h7FFF_FFFF, 32'h8000_0000, 3, -3));
      item_queue.push_back(mk(KIND_WRITE, 0, 0, 4, 32'h7FFF_FFFF, 32'h8000_0000, 4, 0));
      item_queue.push_back(mk(KIND_RESOLVE, 0, 0, 4, 0, 0, 0, 0));
      item_queue.push_back(mk(KIND_WRITE, 1, 0, 4, 9, 9, 9, 9));
      item_queue.push_back(mk(KIND_WRITE, 0, 1, 4, 9, 9, 9, 9));
      item_queue.push_back(mk(KIND_CLEAR, 0, 0, 1, 77, 1, 1, 1));
      item_queue.push_back(mk(KIND_RESOLVE, 0, 0, 4, 0, 0, 0, 0));
      drain();

      for (int p = 0; p < 10; p++) begin
         configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                   phase_cfg[p][3], phase_cfg[p][4]);
         calm = (p == 3);
         if (p == 9) hold_request = 1'b1;
         for (int n = 0; n < phase_cfg[p][5]; n++) item_queue.push_back(rand_item());
         drain();
      end
      calm = 1'b0;

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/sarb_pkg.sv
rtl/sarb_ram.sv
rtl/sample_accumulate_resolve_buffer_top.sv
rtl/sarb_checker.sv
bench/tb_sample_accumulate_resolve_buffer_top.sv
